### rtl/core/tlsm_pkg.sv
package tlsm_pkg;

   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_MAX_TETS   = 4096;

   localparam int COORD_W = 32;
   localparam int SUM_W   = 48;
   localparam int TALLY_W = 16;
   localparam int VERT_W  = 10;
   localparam int SLOT_W  = 12;
   localparam int LANES   = 3;

   typedef enum logic [1:0] {
      CMD_LOAD_POINT = 2'd0,
      CMD_LOAD_TET   = 2'd1,
      CMD_RUN        = 2'd2,
      CMD_READ_POINT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BAD   = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_POINT_COUNT = 2'd0,
      REG_TET_COUNT   = 2'd1,
      REG_PASS_COUNT  = 2'd2,
      REG_NONE        = 2'd3
   } reg_type;

   typedef struct packed {
      logic                     pin;
      logic [LANES-1:0][COORD_W-1:0] crd;
   } pos_type;

   typedef struct packed {
      logic [TALLY_W-1:0]          tally;
      logic [LANES-1:0][SUM_W-1:0] sum;
   } sum_type;

endpackage

### rtl/core/tlsm_div.sv
module tlsm_div import tlsm_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [LANES-1:0][SUM_W-1:0]     dividend,
   input  logic [TALLY_W-1:0]              divisor,
   output logic                            done,
   output logic [LANES-1:0][COORD_W-1:0]   quot
);

   localparam int CNT_W = $clog2(SUM_W);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [TALLY_W-1:0]            dvs_ff, dvs_in;
   logic [LANES-1:0]              neg_ff, neg_in;
   logic [LANES-1:0][TALLY_W-1:0] rem_ff, rem_in;
   logic [LANES-1:0][SUM_W-1:0]   q_ff, q_in;
   logic [LANES-1:0][TALLY_W:0]   trial;
   logic [LANES-1:0][SUM_W-1:0]   mag;

   // magnitude restoring division, one quotient bit per cycle per lane
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {rem_ff[i], q_ff[i][SUM_W-1]};
         mag[i]   = q_ff[i];
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvs_in = divisor;
         for (int i = 0; i < LANES; i++) begin
            neg_in[i] = dividend[i][SUM_W-1];
            q_in[i]   = dividend[i][SUM_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
            rem_in[i] = '0;
         end
      end else if (run_ff) begin
         for (int i = 0; i < LANES; i++) begin
            if (trial[i] >= {1'b0, dvs_ff}) begin
               rem_in[i] = TALLY_W'(trial[i] - {1'b0, dvs_ff});
               q_in[i]   = {q_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][TALLY_W-1:0];
               q_in[i]   = {q_ff[i][SUM_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         quot[i] = neg_ff[i] ? COORD_W'(~mag[i] + 1'b1) : mag[i][COORD_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

### rtl/core/tet_mesh_laplacian_smoother_core.sv
// Laplacian smoother for a tetrahedral mesh, Q16.16 coordinates.
// Command channel: a word is taken when start is high and busy is low.
//   load point / load tet: written in the cycle taken, busy stays low,
//     one word per cycle; rsp_valid pulses the next cycle.
//   read point: position memory read, rsp_valid in the cycle after the take.
//   run: busy rises for the whole run (stays low if pass_count is 0); rsp_valid pulses as it ends.
// Each response word is shown for exactly one cycle with rsp_valid; the
// receiver cannot hold it off, and every command gives one response word.
// The sum memory takes one read-modify-write per vertex of each tet, and
// each moved point waits on the 48-step serial divider.
// Sums are cleared by a sweep at the start of every pass.
// Reset clears control and registers (pass_count resets to 1); point and
// tet memories hold whatever was there until loaded.
// Registers on the APB port: point_count at 0x0, tet_count at 0x4, pass_count at 0x8.
// They must be written only while the block is idle; the block itself does not enforce this.
module tet_mesh_laplacian_smoother_core import tlsm_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int MAX_TETS   = DEF_MAX_TETS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   input  logic signed [COORD_W-1:0]  req_coord_z,
   input  logic                       req_pinned,
   input  logic [VERT_W-1:0]          req_vert_a,
   input  logic [VERT_W-1:0]          req_vert_b,
   input  logic [VERT_W-1:0]          req_vert_c,
   input  logic [VERT_W-1:0]          req_vert_d,
   output logic                       rsp_valid,
   output logic signed [COORD_W-1:0]  rsp_out_x,
   output logic signed [COORD_W-1:0]  rsp_out_y,
   output logic signed [COORD_W-1:0]  rsp_out_z,
   output logic [1:0]                 rsp_status,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int TW  = (MAX_TETS > 1) ? $clog2(MAX_TETS) : 1;
   localparam int TCW = $clog2(MAX_TETS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_TRD, ST_TCHK, ST_PRD, ST_PCAP,
      ST_SRD, ST_SWR, ST_URD, ST_UCHK, ST_UDIV
   } state_type;

   // configuration
   logic [10:0] point_count_ff;
   logic [12:0] tet_count_ff;
   logic [7:0]  pass_count_ff;
   logic        csr_wr;

   // control
   state_type                          state_ff, state_in;
   logic [7:0]                         pass_ff, pass_in;
   logic                               bad_ff, bad_in;
   logic [PCW-1:0]                     idx_ff, idx_in;
   logic [TCW-1:0]                     tet_ff, tet_in;
   logic [1:0]                         k_ff, k_in;
   logic [3:0][VERT_W-1:0]             verts_ff, verts_in;
   logic [3:0][LANES-1:0][COORD_W-1:0] crd_ff, crd_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_read_ff, rsp_read_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;

   // memories
   pos_type          pos_mem [MAX_POINTS];
   logic [39:0]      tet_mem [MAX_TETS];
   sum_type          sum_mem [MAX_POINTS];
   logic             pos_we, tet_we, sum_we;
   logic [PW-1:0]    pos_wa, pos_ra, sum_wa, sum_ra;
   logic [TW-1:0]    tet_wa, tet_ra;
   pos_type          pos_wd, pos_rd_ff;
   logic [39:0]      tet_wd, tet_rd_ff;
   sum_type          sum_wd, sum_rd_ff;

   // divider
   logic                          div_start, div_done;
   logic [LANES-1:0][COORD_W-1:0] div_quot;

   logic [PCW-1:0] live_pts;
   logic [TCW-1:0] live_tets;
   logic [31:0]    slot_ext;
   logic           accept, pt_ok, tet_ok, vert_bad;
   logic [3:0][VERT_W-1:0]          tet_v;
   logic [LANES-1:0][COORD_W+1:0]   other;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         tet_count_ff   <= '0;
         pass_count_ff  <= 8'd1;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_POINT_COUNT: point_count_ff <= pwdata[10:0];
            REG_TET_COUNT:   tet_count_ff   <= pwdata[12:0];
            REG_PASS_COUNT:  pass_count_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_POINT_COUNT: prdata = {21'd0, point_count_ff};
         REG_TET_COUNT:   prdata = {19'd0, tet_count_ff};
         REG_PASS_COUNT:  prdata = {24'd0, pass_count_ff};
         default:         prdata = '0;
      endcase
   end

   // effective counts, clipped to the memory depths
   assign live_pts  = ({21'd0, point_count_ff} < 32'(MAX_POINTS)) ?
                      PCW'(point_count_ff) : PCW'(MAX_POINTS);
   assign live_tets = ({19'd0, tet_count_ff} < 32'(MAX_TETS)) ?
                      TCW'(tet_count_ff) : TCW'(MAX_TETS);

   assign slot_ext = {{(32-SLOT_W){1'b0}}, req_slot};
   assign pt_ok    = slot_ext < 32'(live_pts);
   assign tet_ok   = slot_ext < 32'(live_tets);
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;

   assign tet_v = tet_rd_ff;
   always_comb begin
      vert_bad = 1'b0;
      for (int v = 0; v < 4; v++) begin
         if ({{(32-VERT_W){1'b0}}, tet_v[v]} >= 32'(live_pts)) vert_bad = 1'b1;
      end
   end

   // sum of the three other vertices of the current tet, per lane
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         other[l] = (COORD_W+2)'(signed'(crd_ff[k_ff + 2'd1][l]))
                  + (COORD_W+2)'(signed'(crd_ff[k_ff + 2'd2][l]))
                  + (COORD_W+2)'(signed'(crd_ff[k_ff + 2'd3][l]));
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      bad_in        = bad_ff;
      idx_in        = idx_ff;
      tet_in        = tet_ff;
      k_in          = k_ff;
      verts_in      = verts_ff;
      crd_in        = crd_ff;
      rsp_valid_in  = 1'b0;
      rsp_read_in   = 1'b0;
      rsp_status_in = rsp_status_ff;
      pos_we    = 1'b0;
      pos_wa    = slot_ext[PW-1:0];
      pos_wd    = '0;
      pos_ra    = slot_ext[PW-1:0];
      tet_we    = 1'b0;
      tet_wa    = slot_ext[TW-1:0];
      tet_wd    = {req_vert_d, req_vert_c, req_vert_b, req_vert_a};
      tet_ra    = tet_ff[TW-1:0];
      sum_we    = 1'b0;
      sum_wa    = idx_ff[PW-1:0];
      sum_wd    = '0;
      sum_ra    = idx_ff[PW-1:0];
      div_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOAD_POINT: begin
                     pos_we        = pt_ok;
                     pos_wd.pin    = req_pinned;
                     pos_wd.crd    = {req_coord_z, req_coord_y, req_coord_x};
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pt_ok ? STAT_OK : STAT_RANGE;
                  end
                  CMD_LOAD_TET: begin
                     tet_we        = tet_ok;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = tet_ok ? STAT_OK : STAT_RANGE;
                  end
                  CMD_READ_POINT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_read_in   = pt_ok;
                     rsp_status_in = pt_ok ? STAT_OK : STAT_RANGE;
                  end
                  default: begin
                     if (pass_count_ff == 8'd0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                     end else begin
                        pass_in  = '0;
                        bad_in   = 1'b0;
                        idx_in   = '0;
                        state_in = ST_CLR;
                     end
                  end
               endcase
            end
         end
         ST_CLR: begin
            if (idx_ff == live_pts) begin
               tet_in   = '0;
               state_in = ST_TRD;
            end else begin
               sum_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TRD: begin
            if (tet_ff == live_tets) begin
               idx_in   = '0;
               state_in = ST_URD;
            end else begin
               state_in = ST_TCHK;
            end
         end
         ST_TCHK: begin
            verts_in = tet_v;
            if (vert_bad) begin
               bad_in   = 1'b1;
               tet_in   = tet_ff + 1'b1;
               state_in = ST_TRD;
            end else begin
               k_in     = '0;
               state_in = ST_PRD;
            end
         end
         ST_PRD: begin
            pos_ra   = PW'({{(32-VERT_W){1'b0}}, verts_ff[k_ff]});
            state_in = ST_PCAP;
         end
         ST_PCAP: begin
            crd_in[k_ff] = pos_rd_ff.crd;
            k_in         = k_ff + 1'b1;
            state_in     = (k_ff == 2'd3) ? ST_SRD : ST_PRD;
         end
         ST_SRD: begin
            sum_ra   = PW'({{(32-VERT_W){1'b0}}, verts_ff[k_ff]});
            state_in = ST_SWR;
         end
         ST_SWR: begin
            sum_we       = 1'b1;
            sum_wa       = PW'({{(32-VERT_W){1'b0}}, verts_ff[k_ff]});
            sum_wd.tally = sum_rd_ff.tally + TALLY_W'(3);
            for (int l = 0; l < LANES; l++) begin
               sum_wd.sum[l] = sum_rd_ff.sum[l]
                             + {{(SUM_W-COORD_W-2){other[l][COORD_W+1]}}, other[l]};
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               tet_in   = tet_ff + 1'b1;
               state_in = ST_TRD;
            end else begin
               state_in = ST_SRD;
            end
         end
         ST_URD: begin
            if (idx_ff == live_pts) begin
               pass_in = pass_ff + 1'b1;
               if (pass_ff + 8'd1 == pass_count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bad_ff ? STAT_BAD : STAT_OK;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_CLR;
               end
            end else begin
               pos_ra   = idx_ff[PW-1:0];
               state_in = ST_UCHK;
            end
         end
         ST_UCHK: begin
            if (pos_rd_ff.pin || sum_rd_ff.tally == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_URD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_UDIV;
            end
         end
         ST_UDIV: begin
            if (div_done) begin
               pos_we     = 1'b1;
               pos_wa     = idx_ff[PW-1:0];
               pos_wd.pin = 1'b0;
               pos_wd.crd = div_quot;
               idx_in     = idx_ff + 1'b1;
               state_in   = ST_URD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= '0;
         bad_ff        <= 1'b0;
         idx_ff        <= '0;
         tet_ff        <= '0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_read_ff   <= 1'b0;
         rsp_status_ff <= STAT_OK;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         bad_ff        <= bad_in;
         idx_ff        <= idx_in;
         tet_ff        <= tet_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_status_ff <= rsp_status_in;
      end
      verts_ff <= verts_in;
      crd_ff   <= crd_in;
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (tet_we) tet_mem[tet_wa] <= tet_wd;
      tet_rd_ff <= tet_mem[tet_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      sum_rd_ff <= sum_mem[sum_ra];
   end

   tlsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_rd_ff.sum),
      .divisor  (sum_rd_ff.tally),
      .done     (div_done),
      .quot     (div_quot)
   );

   // ---------------- response ----------------
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_x  = rsp_read_ff ? pos_rd_ff.crd[0] : '0;
   assign rsp_out_y  = rsp_read_ff ? pos_rd_ff.crd[1] : '0;
   assign rsp_out_z  = rsp_read_ff ? pos_rd_ff.crd[2] : '0;

endmodule

### tb/tlsm_checker.sv
module tlsm_checker import tlsm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [1:0]                req_command,
   input  logic [SLOT_W-1:0]         req_slot,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic                      req_pinned,
   input  logic [VERT_W-1:0]         req_vert_a,
   input  logic [VERT_W-1:0]         req_vert_b,
   input  logic [VERT_W-1:0]         req_vert_c,
   input  logic [VERT_W-1:0]         req_vert_d,
   input  logic                      rsp_valid,
   input  logic signed [COORD_W-1:0] rsp_out_x,
   input  logic signed [COORD_W-1:0] rsp_out_y,
   input  logic signed [COORD_W-1:0] rsp_out_z,
   input  logic [1:0]                rsp_status,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [31:0]               pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        due_count,
   output int                        seen_count,
   output int                        run_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = DEF_MAX_POINTS;
   localparam int NTETS = DEF_MAX_TETS;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [1:0]  st;
   } answer_type;

   answer_type due_answers[$];

   logic [10:0] np_reg;
   logic [12:0] nt_reg;
   logic [7:0]  passes_reg;

   logic [31:0] mesh_x [NPTS];
   logic [31:0] mesh_y [NPTS];
   logic [31:0] mesh_z [NPTS];
   bit          mesh_pin [NPTS];
   logic [9:0]  tet_vtx [NTETS][4];
   longint      acc_x [NPTS];
   longint      acc_y [NPTS];
   longint      acc_z [NPTS];
   longint      tally [NPTS];

   initial begin
      fail_count = 0;
      due_count = 0;
      seen_count = 0;
      run_count = 0;
   end

   function automatic int live_points();
      return (np_reg < NPTS) ? int'(np_reg) : NPTS;
   endfunction

   function automatic int live_tets();
      return (nt_reg < NTETS) ? int'(nt_reg) : NTETS;
   endfunction

   // one smoothing pass over the old positions; returns 1 if a tet was skipped
   function automatic bit smooth_pass();
      int np;
      int nt;
      int s;
      int n;
      bit skipped;
      bit ok;
      np = live_points();
      nt = live_tets();
      skipped = 0;
      for (int p = 0; p < NPTS; p++) begin
         acc_x[p] = 0;
         acc_y[p] = 0;
         acc_z[p] = 0;
         tally[p] = 0;
      end
      for (int t = 0; t < nt; t++) begin
         ok = 1;
         for (int i = 0; i < 4; i++)
            if (tet_vtx[t][i] >= np) ok = 0;
         if (!ok) begin
            skipped = 1;
         end else begin
            for (int i = 0; i < 4; i++) begin
               s = tet_vtx[t][i];
               for (int j = 1; j < 4; j++) begin
                  n = tet_vtx[t][(i + j) % 4];
                  acc_x[s] += longint'(signed'(mesh_x[n]));
                  acc_y[s] += longint'(signed'(mesh_y[n]));
                  acc_z[s] += longint'(signed'(mesh_z[n]));
                  tally[s]++;
               end
            end
         end
      end
      for (int p = 0; p < np; p++) begin
         if (!mesh_pin[p] && tally[p] != 0) begin
            mesh_x[p] = 32'(acc_x[p] / tally[p]);
            mesh_y[p] = 32'(acc_y[p] / tally[p]);
            mesh_z[p] = 32'(acc_z[p] / tally[p]);
         end
      end
      return skipped;
   endfunction

   function automatic answer_type smooth_mesh_step();
      answer_type a;
      int slot;
      bit skipped;
      slot = req_slot;
      a = '{x: '0, y: '0, z: '0, st: STAT_OK};
      case (cmd_type'(req_command))
         CMD_LOAD_POINT: begin
            if (slot < live_points()) begin
               mesh_x[slot] = req_coord_x;
               mesh_y[slot] = req_coord_y;
               mesh_z[slot] = req_coord_z;
               mesh_pin[slot] = req_pinned;
            end else a.st = STAT_RANGE;
         end
         CMD_LOAD_TET: begin
            if (slot < live_tets()) begin
               tet_vtx[slot][0] = req_vert_a;
               tet_vtx[slot][1] = req_vert_b;
               tet_vtx[slot][2] = req_vert_c;
               tet_vtx[slot][3] = req_vert_d;
            end else a.st = STAT_RANGE;
         end
         CMD_RUN: begin
            skipped = 0;
            for (int k = 0; k < passes_reg; k++)
               if (smooth_pass()) skipped = 1;
            if (skipped) a.st = STAT_BAD;
         end
         default: begin
            if (slot < live_points()) begin
               a.x = mesh_x[slot];
               a.y = mesh_y[slot];
               a.z = mesh_z[slot];
            end else a.st = STAT_RANGE;
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         np_reg <= '0;
         nt_reg <= '0;
         passes_reg <= 8'd1;
         due_answers.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_type'(paddr[3:2]))
               REG_POINT_COUNT: np_reg <= pwdata[10:0];
               REG_TET_COUNT:   nt_reg <= pwdata[12:0];
               REG_PASS_COUNT:  passes_reg <= pwdata[7:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (cmd_type'(req_command) == CMD_RUN) run_count++;
            due_answers.push_back(smooth_mesh_step());
         end
         if (rsp_valid) begin
            seen_count++;
            if (due_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: x=%h y=%h z=%h status=%0d",
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
            end else begin
               want = due_answers.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y ||
                   rsp_out_z !== want.z || rsp_status !== want.st) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"result mismatch: exp x=%h y=%h z=%h st=%0d,",
                               " got x=%h y=%h z=%h st=%0d"},
                              want.x, want.y, want.z, want.st,
                              rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
               end
            end
         end
      end
      due_count = due_answers.size();
   end

endmodule

### tb/tb_top.sv
module tb_top;
   import tlsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      start = 0;
   logic                      busy;
   logic [1:0]                req_command = '0;
   logic [SLOT_W-1:0]         req_slot = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic                      req_pinned = 0;
   logic [VERT_W-1:0]         req_vert_a = '0;
   logic [VERT_W-1:0]         req_vert_b = '0;
   logic [VERT_W-1:0]         req_vert_c = '0;
   logic [VERT_W-1:0]         req_vert_d = '0;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [1:0]                rsp_status;
   logic                      psel = 0;
   logic                      penable = 0;
   logic                      pwrite = 0;
   logic [3:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   int fail_count;
   int due_count;
   int seen_count;
   int run_count;

   // stimulus-side bookkeeping
   int words_sent = 0;
   int burst_left = 0;
   int live_np = 0;     // effective point count currently programmed
   int live_nt = 0;     // effective tet count currently programmed
   bit pt_loaded [DEF_MAX_POINTS];
   longint cycles = 0;

   tet_mesh_laplacian_smoother_core uut (.*);

   tlsm_checker chk (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // sender: bursts of back-to-back words, random gaps in between
   task automatic send_word(input cmd_type c, input int slot,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input bit pin,
                            input int va, input int vb, input int vc, input int vd);
      if (burst_left == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      req_command <= c;
      req_slot <= SLOT_W'(slot);
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_pinned <= pin;
      req_vert_a <= VERT_W'(va);
      req_vert_b <= VERT_W'(vb);
      req_vert_c <= VERT_W'(vc);
      req_vert_d <= VERT_W'(vd);
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      if (c == CMD_LOAD_POINT && slot < live_np) pt_loaded[slot] = 1;
   endtask

   task automatic load_point(input int slot, input bit pin);
      send_word(CMD_LOAD_POINT, slot, pick_coord(), pick_coord(), pick_coord(), pin,
                $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic load_tet(input int slot, input int va, input int vb,
                           input int vc, input int vd);
      send_word(CMD_LOAD_TET, slot, $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)), va, vb, vc, vd);
   endtask

   task automatic simple_cmd(input cmd_type c, input int slot);
      send_word(c, slot, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   // a read never targets a point that has not been loaded
   task automatic read_point(input int slot);
      if (slot < live_np && !pt_loaded[slot]) slot = 4095;
      simple_cmd(CMD_READ_POINT, slot);
   endtask

   // drain: every answer back, then quiet on the bus before touching registers
   task automatic drain();
      start <= 0;
      burst_left = 0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type r, input logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {r, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic setup_mesh(input logic [31:0] np, input logic [31:0] nt,
                             input logic [31:0] passes);
      drain();
      csr_write(REG_POINT_COUNT, np);
      csr_write(REG_TET_COUNT, nt);
      csr_write(REG_PASS_COUNT, passes);
      live_np = (np[10:0] < DEF_MAX_POINTS) ? int'(np[10:0]) : DEF_MAX_POINTS;
      live_nt = (nt[12:0] < DEF_MAX_TETS) ? int'(nt[12:0]) : DEF_MAX_TETS;
      @(posedge clock);
   endtask

   function automatic int pick_vertex();
      if (live_np > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, live_np - 1);
      return $urandom_range(0, 1023);
   endfunction

   // every point and every tet in use loaded, so a run only sees written entries
   task automatic fill_mesh();
      for (int p = 0; p < live_np; p++) load_point(p, $urandom_range(0, 3) == 0);
      for (int t = 0; t < live_nt; t++)
         load_tet(t, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex());
   endtask

   task automatic random_mix(input int n);
      int r;
      int slot;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            slot = (live_np > 0 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, live_np - 1) : $urandom_range(0, 4095);
            load_point(slot, $urandom_range(0, 3) == 0);
         end else if (r < 60) begin
            slot = (live_nt > 0 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, live_nt - 1) : $urandom_range(0, 4095);
            load_tet(slot, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex());
         end else if (r < 92) begin
            slot = (live_np > 0 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, live_np - 1) : $urandom_range(0, 4095);
            read_point(slot);
         end else begin
            simple_cmd(CMD_RUN, $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values: no points or tets, one pass per run
      load_point(0, 0);
      read_point(0);
      load_tet(0, 0, 1, 2, 3);
      simple_cmd(CMD_RUN, 0);

      // smallest real mesh, then a bad tet and a pinned point
      setup_mesh(4, 1, 1);
      fill_mesh();
      load_tet(0, 0, 1, 2, 3);
      load_point(0, 1);
      simple_cmd(CMD_RUN, 0);
      for (int p = 0; p < 4; p++) read_point(p);
      load_tet(0, 0, 1, 2, 4);
      simple_cmd(CMD_RUN, 0);
      read_point(3);
      load_point(4, 0);
      load_tet(1, 0, 1, 2, 3);
      random_mix(40);

      // register extremes: over-range counts clamp, no passes, unmapped address
      setup_mesh(32'hffff_ffff, 32'hffff_ffff, 0);
      csr_write(REG_NONE, 32'h1234_5678);
      load_point(1023, 1);
      load_point(0, 0);
      read_point(1023);
      read_point(0);
      load_tet(4095, 1023, 0, 1023, 0);
      load_tet(0, 0, 0, 0, 0);
      simple_cmd(CMD_RUN, 0);
      read_point(1023);
      random_mix(30);

      // repeated vertices only
      setup_mesh(1, 2, 1);
      fill_mesh();
      load_tet(0, 0, 0, 0, 0);
      load_tet(1, 0, 0, 0, 0);
      simple_cmd(CMD_RUN, 0);
      read_point(0);
      random_mix(30);

      // most passes on a tiny mesh
      setup_mesh(6, 4, 255);
      fill_mesh();
      simple_cmd(CMD_RUN, 0);
      for (int p = 0; p < 6; p++) read_point(p);

      // bulk random traffic on small meshes
      setup_mesh(12, 16, 2);
      fill_mesh();
      random_mix(120);
      setup_mesh(20, 24, 3);
      fill_mesh();
      random_mix(100);
      setup_mesh(0, 0, 1);
      random_mix(20);

      drain();
      $display("sent %0d command words (%0d runs), checked %0d result words",
               words_sent, run_count, seen_count);
      $display("covered clamped counts, zero passes, 255 passes, bad tets, pinned points");
      if (fail_count == 0 && due_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d failures, %0d result words missing", fail_count, due_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
